>>> hdl/integer_dictionary_builder_assert.svh
// Assertion macros used by the dictionary builder checker
`ifndef INTEGER_DICTIONARY_BUILDER_ASSERT_SVH
`define INTEGER_DICTIONARY_BUILDER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define IDB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dictionary builder check failed (same cycle)");

// Next-cycle implication, disabled during reset
`define IDB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dictionary builder check failed (next cycle)");

`endif

>>> hdl/idb_pkg.sv
// Shared constants, types and functions of the integer dictionary builder
package idb_pkg;

   // Table geometry (power-of-two sizes)
   localparam int BUCKETS  = 1024;
   localparam int ENTRIES  = 1024;
   localparam int BUCKET_W = $clog2(BUCKETS);
   localparam int REF_W    = $clog2(ENTRIES);
   localparam int LINK_W   = REF_W + 1;          // valid bit plus reference
   localparam int CNT_W    = REF_W + 1;          // holds 0..ENTRIES
   localparam int VALUE_W  = 64;
   localparam int KIND_W   = 2;
   localparam int BITS_W   = 4;

   localparam logic [BITS_W-1:0]  BITS_RESET = 4'd10;
   localparam logic [VALUE_W-1:0] HASH_MULT  = 64'h0000_0000_5bd1_e995;
   localparam logic [CNT_W-1:0]   COUNT_CAP  = CNT_W'(ENTRIES);

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_BUCKET_BITS = '0;

   typedef enum logic [KIND_W-1:0] {
      KIND_EXISTING = 2'd0,
      KIND_NEW      = 2'd1,
      KIND_NULL     = 2'd2,
      KIND_NOP      = 2'd3
   } row_kind_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;        // latch the accepted item
      logic sweep;          // clear one bucket head
      logic clear_counts;   // zero totals and result
      logic count_null;
      logic count_nop;
      logic head_rd;        // hash and read bucket head
      logic entry_rd_head;  // read entry named by bucket head
      logic entry_rd_next;  // read entry named by chain link
      logic hit_upd;        // bump dup count of matched entry
      logic miss_upd;       // append entry or flag overflow
      logic load_rsp;       // move result into output register
   } idb_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_clear;
      logic is_null;
      logic is_nop;
      logic head_valid;
      logic match;
      logic next_valid;
      logic sweep_last;
   } idb_status_type;

   // Saturating count increment
   function automatic logic [CNT_W-1:0] count_inc(input logic [CNT_W-1:0] c);
      return (c < COUNT_CAP) ? c + CNT_W'(1) : COUNT_CAP;
   endfunction

   // Bucket index: low bits of value * HASH_MULT, masked to the low bucket_bits bits (at least one)
   function automatic logic [BUCKET_W-1:0] hash_pos(input logic [VALUE_W-1:0] v,
                                                    input logic [BITS_W-1:0] bits);
      logic [2*BUCKET_W-1:0] prod;
      logic [BUCKET_W-1:0]   mask;
      logic [BITS_W-1:0]     eff;
      eff  = (bits == '0) ? BITS_W'(1) : bits;
      prod = v[BUCKET_W-1:0] * HASH_MULT[BUCKET_W-1:0];
      for (int i = 0; i < BUCKET_W; i++) begin
         mask[i] = (i < int'(eff));
      end
      return prod[BUCKET_W-1:0] & mask;
   endfunction

endpackage

>>> hdl/idb_ctrl.sv
// Sequencer of the dictionary builder: handshakes, chain walk and clearing sweep
module idb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  idb_pkg::idb_status_type status,
   output idb_pkg::idb_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_DISPATCH,
      S_HEAD,
      S_WALK,
      S_MISS,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      reply_ff, reply_in;       // sweep belongs to a clear item
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      reply_in     = reply_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = reply_ff ? S_DONE : S_IDLE;
               reply_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.is_clear) begin
               cmd.clear_counts = 1'b1;
               reply_in         = 1'b1;
               state_in         = S_SWEEP;
            end else if (status.is_null) begin
               cmd.count_null = 1'b1;
               state_in       = S_DONE;
            end else if (status.is_nop) begin
               cmd.count_nop = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.head_rd = 1'b1;
               state_in    = S_HEAD;
            end
         end
         S_HEAD: begin
            if (status.head_valid) begin
               cmd.entry_rd_head = 1'b1;
               state_in          = S_WALK;
            end else begin
               state_in = S_MISS;
            end
         end
         S_WALK: begin
            if (status.match) begin
               cmd.hit_upd = 1'b1;
               state_in    = S_DONE;
            end else if (status.next_valid) begin
               cmd.entry_rd_next = 1'b1;
            end else begin
               state_in = S_MISS;
            end
         end
         S_MISS: begin
            cmd.miss_upd = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs; reset starts with a clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/idb_dpath.sv
// Datapath of the dictionary builder: hash, bucket and entry memories, counters
module idb_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [idb_pkg::BITS_W-1:0]           bucket_bits,
   input  logic                                 req_mode,
   input  logic [idb_pkg::VALUE_W-1:0]          req_value,
   input  logic                                 req_is_null,
   input  logic                                 req_is_nop,
   input  idb_pkg::idb_cmd_type                 cmd,
   output idb_pkg::idb_status_type              status,
   output logic [idb_pkg::KIND_W-1:0]           rsp_row_kind,
   output logic [idb_pkg::REF_W-1:0]            rsp_dict_ref,
   output logic [idb_pkg::CNT_W-1:0]            rsp_dup_count,
   output logic [idb_pkg::CNT_W-1:0]            rsp_distinct_count,
   output logic [idb_pkg::CNT_W-1:0]            rsp_null_total,
   output logic [idb_pkg::CNT_W-1:0]            rsp_nop_total,
   output logic                                 rsp_overflow
);

   // Captured item
   logic                          mode_ff, null_ff, nop_ff;
   logic [idb_pkg::VALUE_W-1:0]   value_ff;

   // Bucket heads: valid bit plus head reference
   logic [idb_pkg::LINK_W-1:0]    head_mem [idb_pkg::BUCKETS];
   logic [idb_pkg::LINK_W-1:0]    head_rd_ff;
   logic [idb_pkg::BUCKET_W-1:0]  pos_ff, pos_in;
   logic [idb_pkg::BUCKET_W-1:0]  sweep_cnt_ff;

   // Entry pool
   logic [idb_pkg::VALUE_W-1:0]   entry_value_mem [idb_pkg::ENTRIES];
   logic [idb_pkg::LINK_W-1:0]    entry_next_mem  [idb_pkg::ENTRIES];
   logic [idb_pkg::CNT_W-1:0]     entry_dups_mem  [idb_pkg::ENTRIES];
   logic [idb_pkg::VALUE_W-1:0]   value_rd_ff;
   logic [idb_pkg::LINK_W-1:0]    next_rd_ff;
   logic [idb_pkg::CNT_W-1:0]     dups_rd_ff;
   logic [idb_pkg::REF_W-1:0]     cur_ff;
   logic [idb_pkg::REF_W-1:0]     entry_addr;
   logic                          entry_rd;

   // Counters
   logic [idb_pkg::CNT_W-1:0]     total_ff, null_rows_ff, nop_rows_ff;
   logic [idb_pkg::CNT_W-1:0]     dups_inc;
   logic [idb_pkg::REF_W-1:0]     new_ref;
   logic                          full;
   logic                          append;

   // Pending result and output register
   idb_pkg::row_kind_type         res_kind_ff, rsp_kind_ff;
   logic [idb_pkg::REF_W-1:0]     res_ref_ff, rsp_ref_ff;
   logic [idb_pkg::CNT_W-1:0]     res_dups_ff, rsp_dups_ff;
   logic                          res_ovf_ff, rsp_ovf_ff;
   logic [idb_pkg::CNT_W-1:0]     rsp_distinct_ff, rsp_null_ff, rsp_nop_ff;

   assign pos_in     = idb_pkg::hash_pos(value_ff, bucket_bits);
   assign full       = (total_ff >= idb_pkg::COUNT_CAP);
   assign new_ref    = total_ff[idb_pkg::REF_W-1:0];
   assign append     = cmd.miss_upd && !full;
   assign dups_inc   = idb_pkg::count_inc(dups_rd_ff);
   assign entry_rd   = cmd.entry_rd_head || cmd.entry_rd_next;
   assign entry_addr = cmd.entry_rd_head ? head_rd_ff[idb_pkg::REF_W-1:0]
                                         : next_rd_ff[idb_pkg::REF_W-1:0];

   // Status to the controller
   assign status.is_clear   = mode_ff;
   assign status.is_null    = null_ff;
   assign status.is_nop     = nop_ff;
   assign status.head_valid = head_rd_ff[idb_pkg::REF_W];
   assign status.match      = (value_rd_ff == value_ff);
   assign status.next_valid = next_rd_ff[idb_pkg::REF_W];
   assign status.sweep_last = (sweep_cnt_ff == idb_pkg::BUCKET_W'(idb_pkg::BUCKETS - 1));

   // Item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
         null_ff  <= req_is_null;
         nop_ff   <= req_is_nop;
      end
   end

   // Bucket head memory: sweep clears, append relinks
   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         head_mem[sweep_cnt_ff] <= '0;
      end else if (append) begin
         head_mem[pos_ff] <= {1'b1, new_ref};
      end
      if (cmd.head_rd) begin
         head_rd_ff <= head_mem[pos_in];
         pos_ff     <= pos_in;
      end
   end

   // Sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else if (cmd.sweep) begin
         sweep_cnt_ff <= status.sweep_last ? '0 : sweep_cnt_ff + idb_pkg::BUCKET_W'(1);
      end
   end

   // Entry value and link memories
   always_ff @(posedge clock) begin
      if (append) begin
         entry_value_mem[new_ref] <= value_ff;
         entry_next_mem[new_ref]  <= head_rd_ff;
      end
      if (entry_rd) begin
         value_rd_ff <= entry_value_mem[entry_addr];
         next_rd_ff  <= entry_next_mem[entry_addr];
         cur_ff      <= entry_addr;
      end
   end

   // Entry duplicate counts
   always_ff @(posedge clock) begin
      if (cmd.hit_upd) begin
         entry_dups_mem[cur_ff] <= dups_inc;
      end else if (append) begin
         entry_dups_mem[new_ref] <= idb_pkg::CNT_W'(1);
      end
      if (entry_rd) begin
         dups_rd_ff <= entry_dups_mem[entry_addr];
      end
   end

   // Distinct, null and nop totals
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_counts) begin
         total_ff     <= '0;
         null_rows_ff <= '0;
         nop_rows_ff  <= '0;
      end else begin
         if (append) total_ff <= total_ff + idb_pkg::CNT_W'(1);
         if (cmd.count_null) null_rows_ff <= idb_pkg::count_inc(null_rows_ff);
         if (cmd.count_nop) nop_rows_ff <= idb_pkg::count_inc(nop_rows_ff);
      end
   end

   // Pending result of the item in flight
   always_ff @(posedge clock) begin
      if (cmd.clear_counts || cmd.count_null || cmd.count_nop) begin
         res_kind_ff <= cmd.count_null ? idb_pkg::KIND_NULL :
                        cmd.count_nop  ? idb_pkg::KIND_NOP  : idb_pkg::KIND_EXISTING;
         res_ref_ff  <= '0;
         res_dups_ff <= '0;
         res_ovf_ff  <= 1'b0;
      end else if (cmd.hit_upd) begin
         res_kind_ff <= idb_pkg::KIND_EXISTING;
         res_ref_ff  <= cur_ff;
         res_dups_ff <= dups_inc;
         res_ovf_ff  <= 1'b0;
      end else if (cmd.miss_upd) begin
         res_kind_ff <= idb_pkg::KIND_NEW;
         res_ref_ff  <= full ? '0 : new_ref;
         res_dups_ff <= full ? '0 : idb_pkg::CNT_W'(1);
         res_ovf_ff  <= full;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_kind_ff     <= res_kind_ff;
         rsp_ref_ff      <= res_ref_ff;
         rsp_dups_ff     <= res_dups_ff;
         rsp_ovf_ff      <= res_ovf_ff;
         rsp_distinct_ff <= total_ff;
         rsp_null_ff     <= null_rows_ff;
         rsp_nop_ff      <= nop_rows_ff;
      end
   end

   assign rsp_row_kind       = rsp_kind_ff;
   assign rsp_dict_ref       = rsp_ref_ff;
   assign rsp_dup_count      = rsp_dups_ff;
   assign rsp_distinct_count = rsp_distinct_ff;
   assign rsp_null_total     = rsp_null_ff;
   assign rsp_nop_total      = rsp_nop_ff;
   assign rsp_overflow       = rsp_ovf_ff;

endmodule

>>> hdl/integer_dictionary_builder.sv
// Flow: an accepted value row hashes and reads its bucket head, then walks the chain one entry
//   at a time until a match (dup count bumped) or the chain end (append, or overflow flagged).
// Null and nop rows are counted directly; a clear item zeroes the totals and sweeps all heads.
// The block takes one item at a time: req_ready is high only in the idle state.
// Reset (synchronous, active high) clears counts and runs the bucket head sweep with
//   req_ready low; configuration writes are taken during the sweep. bucket_bits resets to 10.
module integer_dictionary_builder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic [idb_pkg::VALUE_W-1:0]          req_value,
   input  logic                                 req_is_null,
   input  logic                                 req_is_nop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [idb_pkg::KIND_W-1:0]           rsp_row_kind,
   output logic [idb_pkg::REF_W-1:0]            rsp_dict_ref,
   output logic [idb_pkg::CNT_W-1:0]            rsp_dup_count,
   output logic [idb_pkg::CNT_W-1:0]            rsp_distinct_count,
   output logic [idb_pkg::CNT_W-1:0]            rsp_null_total,
   output logic [idb_pkg::CNT_W-1:0]            rsp_nop_total,
   output logic                                 rsp_overflow,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [idb_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [idb_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [idb_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   logic [idb_pkg::BITS_W-1:0] bucket_bits_ff;
   logic                       sel_bucket_bits;
   idb_pkg::idb_cmd_type       cmd;
   idb_pkg::idb_status_type    status;

   // Register file: bucket_bits only
   assign sel_bucket_bits = (csr_paddr[idb_pkg::CSR_ADDR_W-1:2] == idb_pkg::REG_BUCKET_BITS);
   assign csr_pready      = 1'b1;
   assign csr_prdata      = sel_bucket_bits
                            ? {{(idb_pkg::CSR_DATA_W-idb_pkg::BITS_W){1'b0}}, bucket_bits_ff}
                            : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_bits_ff <= idb_pkg::BITS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && sel_bucket_bits) begin
         bucket_bits_ff <= csr_pwdata[idb_pkg::BITS_W-1:0];
      end
   end

   idb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   idb_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .bucket_bits        (bucket_bits_ff),
      .req_mode           (req_mode),
      .req_value          (req_value),
      .req_is_null        (req_is_null),
      .req_is_nop         (req_is_nop),
      .cmd                (cmd),
      .status             (status),
      .rsp_row_kind       (rsp_row_kind),
      .rsp_dict_ref       (rsp_dict_ref),
      .rsp_dup_count      (rsp_dup_count),
      .rsp_distinct_count (rsp_distinct_count),
      .rsp_null_total     (rsp_null_total),
      .rsp_nop_total      (rsp_nop_total),
      .rsp_overflow       (rsp_overflow)
   );

endmodule

>>> hdl/idb_checker.sv
// Port-level checks of the dictionary builder and their binding to the top level
`include "integer_dictionary_builder_assert.svh"

module idb_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [idb_pkg::KIND_W-1:0]           rsp_row_kind,
   input logic [idb_pkg::REF_W-1:0]            rsp_dict_ref,
   input logic [idb_pkg::CNT_W-1:0]            rsp_dup_count,
   input logic [idb_pkg::CNT_W-1:0]            rsp_distinct_count,
   input logic                                 rsp_overflow
);

   // A stalled result item stays offered
   `IDB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A matched entry with a nonzero reference has been seen at least twice
   `IDB_ASSERT_NOW(a_hit_dups, clock, reset,
      rsp_valid && rsp_row_kind == idb_pkg::KIND_EXISTING && rsp_dict_ref != '0,
      rsp_dup_count >= idb_pkg::CNT_W'(2))

   // Overflow only on a new value with the pool full
   `IDB_ASSERT_NOW(a_overflow, clock, reset, rsp_valid && rsp_overflow,
      rsp_row_kind == idb_pkg::KIND_NEW && rsp_dict_ref == '0 &&
      rsp_distinct_count == idb_pkg::COUNT_CAP)

   // A fresh entry takes the last reference handed out
   `IDB_ASSERT_NOW(a_new_ref, clock, reset,
      rsp_valid && rsp_row_kind == idb_pkg::KIND_NEW && !rsp_overflow,
      rsp_dup_count == idb_pkg::CNT_W'(1) &&
      rsp_dict_ref == idb_pkg::REF_W'(rsp_distinct_count - idb_pkg::CNT_W'(1)))

   // Null and nop rows carry no reference
   `IDB_ASSERT_NOW(a_null_ref, clock, reset,
      rsp_valid && (rsp_row_kind == idb_pkg::KIND_NULL || rsp_row_kind == idb_pkg::KIND_NOP),
      rsp_dict_ref == '0 && rsp_dup_count == '0 && !rsp_overflow)

endmodule

bind integer_dictionary_builder idb_checker u_idb_checker (.*);
